FILE: src/lobm_pkg.sv
// Shared types and codes of the limit order book matcher.
package lobm_pkg;

    localparam int ORDERS_DEF = 32;
    localparam int SUM_W      = 37;

    typedef enum logic [1:0] {
        FN_PLACE  = 2'd0,
        FN_CANCEL = 2'd1,
        FN_ADD    = 2'd2,
        FN_REDUCE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        TIF_GTC = 2'd0,
        TIF_IOC = 2'd1,
        TIF_FOK = 2'd2,
        TIF_AON = 2'd3
    } t_tif;

    typedef enum logic [2:0] {
        K_ACCEPTED   = 3'd0,
        K_REJECTED   = 3'd1,
        K_TRADE      = 3'd2,
        K_CANCELLED  = 3'd3,
        K_CANCEL_REJ = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        R_NONE    = 3'd0,
        R_NONPOS  = 3'd1,
        R_UNSUPP  = 3'd2,
        R_DUP     = 3'd3,
        R_NOLIQ   = 3'd4,
        R_TIF     = 3'd5,
        R_FULL    = 3'd6,
        R_UNKNOWN = 3'd7
    } t_reason;

    typedef enum logic [2:0] {
        M_BEST,
        M_AVAIL,
        M_FIND,
        M_FREE,
        M_RED
    } t_mode;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_TAKE,
        WR_KILL,
        WR_INS
    } t_wop;

    typedef struct packed {
        t_mode       mode;
        logic        side;
        logic [31:0] price;
        logic [31:0] key;
        logic [31:0] now;
    } t_sweep;

    typedef struct packed {
        t_wop        op;
        logic [30:0] amt;
        logic        side;
        logic [31:0] price;
        logic [31:0] id;
        logic        anon;
        logic [30:0] rem;
        logic [30:0] trd;
        logic [31:0] arrival;
    } t_wr;

    typedef struct packed {
        logic             found;
        logic [31:0]      price;
        logic [31:0]      age;
        logic [31:0]      id;
        logic             anon;
        logic [30:0]      rem;
        logic [30:0]      trd;
        logic [SUM_W-1:0] sum;
    } t_cand;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] id;
        logic [31:0] cid;
        logic [31:0] tprice;
        logic [31:0] amount;
        logic [30:0] rem;
        logic [30:0] trd;
        logic [30:0] crem;
        logic [30:0] ctrd;
        t_reason     reason;
        logic        canon;
    } t_res;

endpackage

FILE: src/lobm_cell.sv
// One book slot: holds a resting order and merges it into the passing candidate.
module lobm_cell #(
    parameter int ORDERS = lobm_pkg::ORDERS_DEF,
    parameter int IDX    = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lobm_pkg::t_sweep            i_sweep,
    input  lobm_pkg::t_wr               i_wr,
    input  logic [$clog2(ORDERS)-1:0]   i_wr_idx,
    input  lobm_pkg::t_cand             i_cand,
    input  logic [$clog2(ORDERS)-1:0]   i_cand_idx,
    output lobm_pkg::t_cand             o_cand,
    output logic [$clog2(ORDERS)-1:0]   o_cand_idx
);
    localparam int IW = $clog2(ORDERS);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic        r_valid;
    logic        r_side;
    logic [31:0] r_price;
    logic [31:0] r_id;
    logic        r_anon;
    logic [30:0] r_rem;
    logic [30:0] r_trd;
    logic [31:0] r_arr;

    logic [31:0] age;
    logic        crossing;
    logic        better;
    logic        take;
    logic        add;

    assign age      = i_sweep.now - r_arr;
    assign crossing = r_valid && (r_side != i_sweep.side) &&
                      (i_sweep.side ? (i_sweep.price <= r_price) : (i_sweep.price >= r_price));
    assign better = !i_cand.found ||
                    (i_sweep.side ? (r_price > i_cand.price) : (r_price < i_cand.price)) ||
                    ((r_price == i_cand.price) && (age > i_cand.age));

    always_comb begin
        take = 1'b0;
        add  = 1'b0;
        unique case (i_sweep.mode)
            lobm_pkg::M_BEST:  take = crossing && better;
            lobm_pkg::M_AVAIL: add  = crossing;
            lobm_pkg::M_FIND:  take = r_valid && !r_anon && (r_id == i_sweep.key) && !i_cand.found;
            lobm_pkg::M_FREE:  take = !r_valid && !i_cand.found;
            lobm_pkg::M_RED:   take = r_valid && r_anon && (r_side == i_sweep.side) &&
                                      (r_price == i_sweep.price) &&
                                      (!i_cand.found || (age > i_cand.age));
            default:           take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_cand.found <= 1'b1;
            o_cand.price <= r_price;
            o_cand.age   <= age;
            o_cand.id    <= r_id;
            o_cand.anon  <= r_anon;
            o_cand.rem   <= r_rem;
            o_cand.trd   <= r_trd;
            o_cand_idx   <= MY_IDX;
        end else begin
            o_cand.found <= i_cand.found;
            o_cand.price <= i_cand.price;
            o_cand.age   <= i_cand.age;
            o_cand.id    <= i_cand.id;
            o_cand.anon  <= i_cand.anon;
            o_cand.rem   <= i_cand.rem;
            o_cand.trd   <= i_cand.trd;
            o_cand_idx   <= i_cand_idx;
        end
        o_cand.sum <= i_cand.sum + (add ? {{(lobm_pkg::SUM_W-31){1'b0}}, r_rem}
                                        : {lobm_pkg::SUM_W{1'b0}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_idx == MY_IDX) begin
            unique case (i_wr.op)
                lobm_pkg::WR_TAKE: begin
                    r_rem <= r_rem - i_wr.amt;
                    r_trd <= r_trd + i_wr.amt;
                    if (r_rem == i_wr.amt) begin
                        r_valid <= 1'b0;
                    end
                end
                lobm_pkg::WR_KILL: r_valid <= 1'b0;
                lobm_pkg::WR_INS: begin
                    r_valid <= 1'b1;
                    r_side  <= i_wr.side;
                    r_price <= i_wr.price;
                    r_id    <= i_wr.id;
                    r_anon  <= i_wr.anon;
                    r_rem   <= i_wr.rem;
                    r_trd   <= i_wr.trd;
                    r_arr   <= i_wr.arrival;
                end
                lobm_pkg::WR_NONE: r_valid <= r_valid;
                default:           r_valid <= r_valid;
            endcase
        end
    end

endmodule

FILE: src/lobm_ctrl.sv
// Sequencer: decodes an item, runs book scans through the cell row, forms results.
module lobm_ctrl #(
    parameter int ORDERS = lobm_pkg::ORDERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_func,
    input  logic [31:0]                 i_order_id,
    input  logic                        i_anonymous,
    input  logic                        i_side,
    input  logic [31:0]                 i_price,
    input  logic [31:0]                 i_quantity,
    input  logic                        i_order_is_stop,
    input  logic [1:0]                  i_time_in_force,
    input  lobm_pkg::t_cand             i_cand,
    input  logic [$clog2(ORDERS)-1:0]   i_cand_idx,
    output lobm_pkg::t_sweep            o_sweep,
    output lobm_pkg::t_wr               o_wr,
    output logic [$clog2(ORDERS)-1:0]   o_wr_idx,
    output lobm_pkg::t_res              o_res,
    output logic                        o_res_valid,
    output logic                        o_last
);
    localparam int IW        = $clog2(ORDERS);
    localparam int CW        = $clog2(ORDERS + 2);
    localparam logic [CW-1:0] SWEEP_LEN = CW'(ORDERS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_DUP, S_CHK, S_AVL, S_ACC, S_LOOP, S_BEST,
        S_REST, S_FREEP, S_FINDC, S_FREEA, S_RLOOP, S_RED, S_FLUSH
    } t_state;

    t_state          r_state;
    lobm_pkg::t_func r_func;
    logic [31:0]     r_id;
    logic            r_anon;
    logic            r_side;
    logic [31:0]     r_price;
    logic [31:0]     r_qty;
    logic            r_stop;
    lobm_pkg::t_tif  r_tif;
    logic [30:0]     r_rem;
    logic [30:0]     r_trd;
    logic [30:0]     r_vol;
    logic            r_fill;
    logic [CW-1:0]   r_cnt;
    lobm_pkg::t_mode r_mode;
    logic [31:0]     r_now;
    lobm_pkg::t_wr   r_wr;
    logic [IW-1:0]   r_widx;
    lobm_pkg::t_res  r_pend;
    logic            r_phave;
    lobm_pkg::t_res  r_out;
    logic            r_oval;
    logic            r_olast;

    logic        qpos;
    logic [31:0] rid;
    logic [30:0] t_fill;
    logic [30:0] t_red;
    logic        scan_done;

    assign busy      = (r_state != S_IDLE);
    assign qpos      = !r_qty[31] && (r_qty != 32'd0);
    assign rid       = r_anon ? 32'd0 : r_id;
    assign t_fill    = (r_rem < i_cand.rem) ? r_rem : i_cand.rem;
    assign t_red     = (r_vol < i_cand.rem) ? r_vol : i_cand.rem;
    assign scan_done = (r_cnt == SWEEP_LEN);

    assign o_sweep.mode  = r_mode;
    assign o_sweep.side  = r_side;
    assign o_sweep.price = r_price;
    assign o_sweep.key   = r_id;
    assign o_sweep.now   = r_now;
    assign o_wr          = r_wr;
    assign o_wr_idx      = r_widx;
    assign o_res         = r_out;
    assign o_res_valid   = r_oval;
    assign o_last        = r_olast;

    always_ff @(posedge i_clk) begin
        lobm_pkg::t_res v_res;
        logic           v_emit;
        v_res  = '0;
        v_emit = 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_phave <= 1'b0;
            r_now   <= 32'd0;
            r_wr.op <= lobm_pkg::WR_NONE;
            r_cnt   <= '0;
            r_mode  <= lobm_pkg::M_FREE;
        end else begin
            r_oval  <= 1'b0;
            r_wr.op <= lobm_pkg::WR_NONE;
            if (r_state != S_IDLE && !scan_done) begin
                r_cnt <= r_cnt + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= lobm_pkg::t_func'(i_func);
                        r_id    <= i_order_id;
                        r_anon  <= i_anonymous;
                        r_side  <= i_side;
                        r_price <= i_price;
                        r_qty   <= i_quantity;
                        r_stop  <= i_order_is_stop;
                        r_tif   <= lobm_pkg::t_tif'(i_time_in_force);
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_cnt <= '0;
                    unique case (r_func)
                        lobm_pkg::FN_PLACE: begin
                            if (!qpos || r_stop) begin
                                v_emit        = !r_anon;
                                v_res.kind    = lobm_pkg::K_REJECTED;
                                v_res.id      = rid;
                                v_res.amount  = r_qty;
                                v_res.reason  = !qpos ? lobm_pkg::R_NONPOS : lobm_pkg::R_UNSUPP;
                                r_state       <= S_FLUSH;
                            end else if (!r_anon) begin
                                r_mode  <= lobm_pkg::M_FIND;
                                r_state <= S_DUP;
                            end else begin
                                r_state <= S_CHK;
                            end
                        end
                        lobm_pkg::FN_CANCEL: begin
                            if (r_anon) begin
                                v_emit       = 1'b1;
                                v_res.kind   = lobm_pkg::K_CANCEL_REJ;
                                v_res.id     = r_id;
                                v_res.reason = lobm_pkg::R_UNKNOWN;
                                r_state      <= S_FLUSH;
                            end else begin
                                r_mode  <= lobm_pkg::M_FIND;
                                r_state <= S_FINDC;
                            end
                        end
                        lobm_pkg::FN_ADD: begin
                            r_mode  <= lobm_pkg::M_FREE;
                            r_state <= qpos ? S_FREEA : S_FLUSH;
                        end
                        lobm_pkg::FN_REDUCE: begin
                            r_vol   <= r_qty[30:0];
                            r_state <= qpos ? S_RLOOP : S_FLUSH;
                        end
                        default: r_state <= S_FLUSH;
                    endcase
                end
                S_DUP: begin
                    if (scan_done) begin
                        if (i_cand.found) begin
                            v_emit       = 1'b1;
                            v_res.kind   = lobm_pkg::K_REJECTED;
                            v_res.id     = rid;
                            v_res.amount = r_qty;
                            v_res.reason = lobm_pkg::R_DUP;
                            r_state      <= S_FLUSH;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    r_cnt <= '0;
                    if (r_tif == lobm_pkg::TIF_FOK || r_tif == lobm_pkg::TIF_AON) begin
                        r_mode  <= lobm_pkg::M_AVAIL;
                        r_state <= S_AVL;
                    end else begin
                        r_fill  <= 1'b1;
                        r_state <= S_ACC;
                    end
                end
                S_AVL: begin
                    if (scan_done) begin
                        if (r_tif == lobm_pkg::TIF_FOK &&
                            i_cand.sum < {{(lobm_pkg::SUM_W-31){1'b0}}, r_qty[30:0]}) begin
                            v_emit       = !r_anon;
                            v_res.kind   = lobm_pkg::K_REJECTED;
                            v_res.id     = rid;
                            v_res.amount = r_qty;
                            v_res.reason = lobm_pkg::R_NOLIQ;
                            r_state      <= S_FLUSH;
                        end else begin
                            r_fill  <= (i_cand.sum >=
                                        {{(lobm_pkg::SUM_W-31){1'b0}}, r_qty[30:0]});
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    v_emit       = !r_anon;
                    v_res.kind   = lobm_pkg::K_ACCEPTED;
                    v_res.id     = rid;
                    v_res.amount = r_qty;
                    v_res.rem    = r_qty[30:0];
                    r_rem        <= r_qty[30:0];
                    r_trd        <= 31'd0;
                    r_state      <= S_LOOP;
                end
                S_LOOP: begin
                    r_cnt <= '0;
                    if (r_fill && r_rem != 31'd0) begin
                        r_mode  <= lobm_pkg::M_BEST;
                        r_state <= S_BEST;
                    end else begin
                        r_state <= S_REST;
                    end
                end
                S_BEST: begin
                    if (scan_done) begin
                        if (i_cand.found) begin
                            r_wr.op      <= lobm_pkg::WR_TAKE;
                            r_wr.amt     <= t_fill;
                            r_widx       <= i_cand_idx;
                            r_rem        <= r_rem - t_fill;
                            r_trd        <= r_trd + t_fill;
                            v_emit       = 1'b1;
                            v_res.kind   = lobm_pkg::K_TRADE;
                            v_res.id     = rid;
                            v_res.cid    = i_cand.id;
                            v_res.tprice = i_cand.price;
                            v_res.amount = {1'b0, t_fill};
                            v_res.rem    = r_rem - t_fill;
                            v_res.trd    = r_trd + t_fill;
                            v_res.crem   = i_cand.rem - t_fill;
                            v_res.ctrd   = i_cand.trd + t_fill;
                            v_res.canon  = i_cand.anon;
                            r_state      <= S_LOOP;
                        end else begin
                            r_state <= S_REST;
                        end
                    end
                end
                S_REST: begin
                    r_cnt <= '0;
                    if (r_rem == 31'd0) begin
                        r_state <= S_FLUSH;
                    end else if (r_tif == lobm_pkg::TIF_GTC || r_tif == lobm_pkg::TIF_AON) begin
                        r_mode  <= lobm_pkg::M_FREE;
                        r_state <= S_FREEP;
                    end else begin
                        v_emit       = !r_anon;
                        v_res.kind   = lobm_pkg::K_CANCELLED;
                        v_res.id     = rid;
                        v_res.amount = {1'b0, r_rem};
                        v_res.trd    = r_trd;
                        v_res.reason = lobm_pkg::R_TIF;
                        r_state      <= S_FLUSH;
                    end
                end
                S_FREEP: begin
                    if (scan_done) begin
                        if (i_cand.found) begin
                            r_wr.op      <= lobm_pkg::WR_INS;
                            r_wr.side    <= r_side;
                            r_wr.price   <= r_price;
                            r_wr.id      <= rid;
                            r_wr.anon    <= r_anon;
                            r_wr.rem     <= r_rem;
                            r_wr.trd     <= r_trd;
                            r_wr.arrival <= r_now;
                            r_widx       <= i_cand_idx;
                            r_now        <= r_now + 32'd1;
                        end else begin
                            v_emit       = !r_anon;
                            v_res.kind   = lobm_pkg::K_CANCELLED;
                            v_res.id     = rid;
                            v_res.amount = {1'b0, r_rem};
                            v_res.trd    = r_trd;
                            v_res.reason = lobm_pkg::R_FULL;
                        end
                        r_state <= S_FLUSH;
                    end
                end
                S_FINDC: begin
                    if (scan_done) begin
                        v_emit   = 1'b1;
                        v_res.id = r_id;
                        if (i_cand.found) begin
                            v_res.kind   = lobm_pkg::K_CANCELLED;
                            v_res.amount = {1'b0, i_cand.rem};
                            v_res.trd    = i_cand.trd;
                            r_wr.op      <= lobm_pkg::WR_KILL;
                            r_widx       <= i_cand_idx;
                        end else begin
                            v_res.kind   = lobm_pkg::K_CANCEL_REJ;
                            v_res.reason = lobm_pkg::R_UNKNOWN;
                        end
                        r_state <= S_FLUSH;
                    end
                end
                S_FREEA: begin
                    if (scan_done) begin
                        if (i_cand.found) begin
                            r_wr.op      <= lobm_pkg::WR_INS;
                            r_wr.side    <= r_side;
                            r_wr.price   <= r_price;
                            r_wr.id      <= 32'd0;
                            r_wr.anon    <= 1'b1;
                            r_wr.rem     <= r_qty[30:0];
                            r_wr.trd     <= 31'd0;
                            r_wr.arrival <= r_now;
                            r_widx       <= i_cand_idx;
                            r_now        <= r_now + 32'd1;
                        end
                        r_state <= S_FLUSH;
                    end
                end
                S_RLOOP: begin
                    r_cnt   <= '0;
                    r_mode  <= lobm_pkg::M_RED;
                    r_state <= (r_vol != 31'd0) ? S_RED : S_FLUSH;
                end
                S_RED: begin
                    if (scan_done) begin
                        if (i_cand.found) begin
                            r_wr.op  <= lobm_pkg::WR_TAKE;
                            r_wr.amt <= t_red;
                            r_widx   <= i_cand_idx;
                            r_vol    <= r_vol - t_red;
                            r_state  <= S_RLOOP;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (r_phave) begin
                        r_out   <= r_pend;
                        r_oval  <= 1'b1;
                        r_olast <= 1'b1;
                    end
                    r_phave <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (v_emit) begin
                if (r_phave) begin
                    r_out   <= r_pend;
                    r_oval  <= 1'b1;
                    r_olast <= 1'b0;
                end
                r_pend  <= v_res;
                r_phave <= 1'b1;
            end
        end
    end

endmodule

FILE: src/limit_order_book_matcher.sv
// Top level: price-time-priority order book built as a row of slot cells and a sequencer.
// An item is taken when start is high and busy is low; busy falls in the same cycle
// that its last result is shown, and the next item can be taken in the first cycle
// that busy is low. Results appear one per cycle at most, each for a single cycle
// on o_res_valid, and o_last marks the final one; the receiver cannot hold them
// back. Every look at the book is one scan of a candidate word down the row of
// ORDERS cells, begun by a state that sets it up. A place rejected for its
// quantity or a stop flag, a cancel of an anonymous id, and an add or reduce
// with a non-positive quantity go from decode straight to the flush with no scan;
// a cancel, a duplicate reject and an add each cost one scan. A place costs one
// scan for the duplicate check of an identified order, one for the depth test of
// fill-or-kill and all-or-none, one per trade, one more when the crossing depth
// runs out before the order is filled, and one to find a free slot when a
// remainder rests; a reduce costs one scan per touched order and one more when
// the anonymous depth runs out first.
module limit_order_book_matcher #(
    parameter int ORDERS = lobm_pkg::ORDERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_order_id,
    input  logic        i_anonymous,
    input  logic        i_side,
    input  logic [31:0] i_price,
    input  logic [31:0] i_quantity,
    input  logic        i_order_is_stop,
    input  logic [1:0]  i_time_in_force,
    output logic        o_res_valid,
    output logic [2:0]  o_kind,
    output logic [31:0] o_order_id_res,
    output logic [31:0] o_counter_id,
    output logic [31:0] o_trade_price,
    output logic [31:0] o_amount,
    output logic [30:0] o_remaining,
    output logic [30:0] o_traded_total,
    output logic [30:0] o_counter_remaining,
    output logic [30:0] o_counter_traded,
    output logic [2:0]  o_reason,
    output logic        o_counter_anonymous,
    output logic        o_last
);
    localparam int IW = $clog2(ORDERS);

    lobm_pkg::t_sweep sweep;
    lobm_pkg::t_wr    wr;
    logic [IW-1:0]    wr_idx;
    lobm_pkg::t_res   res;
    lobm_pkg::t_cand  cand     [ORDERS+1];
    logic [IW-1:0]    cand_idx [ORDERS+1];

    assign cand[0]     = '0;
    assign cand_idx[0] = '0;

    lobm_ctrl #(.ORDERS(ORDERS)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_order_id      (i_order_id),
        .i_anonymous     (i_anonymous),
        .i_side          (i_side),
        .i_price         (i_price),
        .i_quantity      (i_quantity),
        .i_order_is_stop (i_order_is_stop),
        .i_time_in_force (i_time_in_force),
        .i_cand          (cand[ORDERS]),
        .i_cand_idx      (cand_idx[ORDERS]),
        .o_sweep         (sweep),
        .o_wr            (wr),
        .o_wr_idx        (wr_idx),
        .o_res           (res),
        .o_res_valid     (o_res_valid),
        .o_last          (o_last)
    );

    for (genvar g = 0; g < ORDERS; g++) begin : g_cell
        lobm_cell #(.ORDERS(ORDERS), .IDX(g)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_sweep    (sweep),
            .i_wr       (wr),
            .i_wr_idx   (wr_idx),
            .i_cand     (cand[g]),
            .i_cand_idx (cand_idx[g]),
            .o_cand     (cand[g+1]),
            .o_cand_idx (cand_idx[g+1])
        );
    end

    assign o_kind              = res.kind;
    assign o_order_id_res      = res.id;
    assign o_counter_id        = res.cid;
    assign o_trade_price       = res.tprice;
    assign o_amount            = res.amount;
    assign o_remaining         = res.rem;
    assign o_traded_total      = res.trd;
    assign o_counter_remaining = res.crem;
    assign o_counter_traded    = res.ctrd;
    assign o_reason            = res.reason;
    assign o_counter_anonymous = res.canon;

endmodule

FILE: src/lobm_chk.sv
// Port-level checks of the order book matcher, bound to the top level.
module lobm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_res_valid,
    input logic [2:0]  o_kind,
    input logic [2:0]  o_reason,
    input logic        o_last
);
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_last |-> !busy)
        else $error("final result shown while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_last |-> busy)
        else $error("non-final result shown while idle");

    a_trade_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind == lobm_pkg::K_TRADE |-> o_reason == lobm_pkg::R_NONE)
        else $error("trade carries a reason");
endmodule

bind limit_order_book_matcher lobm_chk u_lobm_chk (.*);
